// ===== rtl/c8_pkg.sv =====
`default_nettype none

package c8_pkg;

   localparam int ADDR_W = 12;
   localparam int MEM_BYTES = 4096;
   localparam int SCREEN_WIDTH = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

   // request operations
   localparam logic [1:0] OPER_LOAD = 2'd0;
   localparam logic [1:0] OPER_EXEC = 2'd1;
   localparam logic [1:0] OPER_RESUME = 2'd2;
   localparam logic [1:0] OPER_ROW = 2'd3;

   // fault codes
   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_UNDEF = 2'd1;
   localparam logic [1:0] FAULT_OVERFLOW = 2'd2;
   localparam logic [1:0] FAULT_UNDERFLOW = 2'd3;

   // opcode constants
   localparam logic [15:0] OPC_CLS = 16'h00E0;
   localparam logic [15:0] OPC_RET = 16'h00EE;
   localparam logic [3:0] GRP_SYS = 4'h0;
   localparam logic [3:0] GRP_DRAW = 4'hD;
   localparam logic [3:0] GRP_MISC = 4'hF;
   localparam logic [7:0] NN_SKP = 8'h9E;
   localparam logic [7:0] NN_SKNP = 8'hA1;
   localparam logic [7:0] NN_GET_DT = 8'h07;
   localparam logic [7:0] NN_WAIT = 8'h0A;
   localparam logic [7:0] NN_SET_DT = 8'h15;
   localparam logic [7:0] NN_SET_ST = 8'h18;
   localparam logic [7:0] NN_ADD_I = 8'h1E;
   localparam logic [7:0] NN_FONT = 8'h29;
   localparam logic [7:0] NN_BCD = 8'h33;
   localparam logic [7:0] NN_STORE = 8'h55;
   localparam logic [7:0] NN_LOAD = 8'h65;

   typedef enum logic [3:0] {
      UOP_IDLE,
      UOP_LOAD,
      UOP_RESUME,
      UOP_ROW,
      UOP_START,
      UOP_FETCH_HI,
      UOP_FETCH_LO,
      UOP_LATCH,
      UOP_EXEC,
      UOP_RET_RD,
      UOP_RET_DO,
      UOP_BCD,
      UOP_STORE,
      UOP_LOADV,
      UOP_DRAW
   } uop_type;

   typedef struct packed {
      uop_type uop;
      logic [4:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic [15:0] opcode;
      logic waiting;
      logic stack_empty;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/c8_if.sv =====
`default_nettype none

interface c8_req_if;
   logic valid;
   logic ready;
   logic [1:0] operation;
   logic [11:0] address;
   logic [7:0] data;
   logic [15:0] keys_down;
   logic [7:0] random_byte;

   modport source (output valid, operation, address, data, keys_down, random_byte,
                   input ready);
   modport sink (input valid, operation, address, data, keys_down, random_byte,
                 output ready);
endinterface

interface c8_rsp_if;
   logic valid;
   logic ready;
   logic [11:0] program_counter;
   logic draw_flag;
   logic waiting_for_key;
   logic [1:0] fault_code;
   logic [63:0] screen_row;
   logic [7:0] delay_value;
   logic [7:0] sound_value;

   modport source (output valid, program_counter, draw_flag, waiting_for_key, fault_code,
                   screen_row, delay_value, sound_value, input ready);
   modport sink (input valid, program_counter, draw_flag, waiting_for_key, fault_code,
                 screen_row, delay_value, sound_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/c8_datapath.sv =====
`default_nettype none

module c8_datapath #(
   parameter int STACK_DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input c8_pkg::cmd_type cmd,
   output c8_pkg::status_type status,
   input wire logic [11:0] req_address,
   input wire logic [7:0] req_data,
   input wire logic [15:0] req_keys_down,
   input wire logic [7:0] req_random_byte,
   output logic [11:0] rsp_program_counter,
   output logic rsp_draw_flag,
   output logic rsp_waiting_for_key,
   output logic [1:0] rsp_fault_code,
   output logic [63:0] rsp_screen_row,
   output logic [7:0] rsp_delay_value,
   output logic [7:0] rsp_sound_value
);
   import c8_pkg::*;

   localparam int SW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);

   function automatic logic [3:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
      logic [1:0] h;
      logic [6:0] r;
      logic [14:0] p;
      logic [3:0] t;
      logic [3:0] o;
      h = (v >= 8'd200) ? 2'd2 : (v >= 8'd100) ? 2'd1 : 2'd0;
      r = 7'(v - ((h == 2'd2) ? 8'd200 : (h == 2'd1) ? 8'd100 : 8'd0));
      // divide by ten through the reciprocal, exact below 1029
      p = {8'b0, r} * 15'd205;
      t = 4'(p >> 11);
      o = 4'(r - ({3'b0, t} * 7'd10));
      case (sel)
         2'd0: bcd_digit = {2'b0, h};
         2'd1: bcd_digit = t;
         default: bcd_digit = o;
      endcase
   endfunction

   logic [7:0] mem [0:MEM_BYTES-1];
   logic [7:0] mem_q_ff;
   logic [11:0] stack [0:STACK_DEPTH-1];
   logic [11:0] stk_q_ff;

   logic [7:0] v_ff [0:15];
   logic [11:0] pc_ff;
   logic [15:0] i_ff;
   logic [DW-1:0] depth_ff;
   logic [63:0] frame_ff [0:SCREEN_HEIGHT-1];
   logic [7:0] delay_ff, sound_ff;
   logic wait_ff;
   logic [3:0] target_ff;
   logic draw_ff, hit_ff;
   logic [1:0] fault_ff;
   logic [7:0] op_hi_ff, op_lo_ff;
   logic [15:0] keys_ff;
   logic [7:0] rnd_ff;
   logic [63:0] row_ff;

   logic [15:0] opc;
   logic [3:0] x, y, n;
   logic [7:0] nn, vx, vy;
   logic [11:0] nnn, ix_addr, pc_plus2, pc_plus4, pc_exec;
   logic mem_we;
   logic [11:0] mem_waddr, mem_raddr;
   logic [7:0] mem_wdata;
   logic stack_full, stk_we;
   logic [DW-1:0] depth_m1;
   logic [7:0] alu_r;
   logic alu_f, alu_wf, alu_ok;
   logic [8:0] alu_sum, draw_y;
   logic [15:0] isum;
   logic draw_ok, draw_hit;
   logic [63:0] draw_bits;

   assign opc = {op_hi_ff, op_lo_ff};
   assign x = opc[11:8];
   assign y = opc[7:4];
   assign n = opc[3:0];
   assign nn = opc[7:0];
   assign nnn = opc[11:0];
   assign vx = v_ff[x];
   assign vy = v_ff[y];
   assign ix_addr = i_ff[11:0] + {7'b0, cmd.cnt};
   assign pc_plus2 = pc_ff + 12'd2;
   assign pc_plus4 = pc_ff + 12'd4;
   assign stack_full = (depth_ff == DW'(STACK_DEPTH));
   assign depth_m1 = depth_ff - 1'b1;
   assign stk_we = (cmd.uop == UOP_EXEC) && (opc[15:12] == 4'h2) && !stack_full;
   assign isum = i_ff + {8'b0, vx};

   assign draw_y = {1'b0, vy} + {4'b0, cmd.cnt} - 9'd1;
   assign draw_ok = (vx[7:6] == 2'b0) && (draw_y[8:5] == 4'b0) && (cmd.cnt != 5'd0);
   assign draw_bits = {mem_q_ff, 56'b0} >> vx[5:0];
   assign draw_hit = draw_ok && ((frame_ff[draw_y[4:0]] & draw_bits) != 64'b0);

   assign status.opcode = opc;
   assign status.waiting = wait_ff;
   assign status.stack_empty = (depth_ff == '0);

   // next PC for the execute step: advance, jump or skip
   always_comb begin
      pc_exec = pc_plus2;
      case (opc[15:12])
         4'h1: pc_exec = nnn;
         4'h2: if (!stack_full) pc_exec = nnn;
         4'h3: if (vx == nn) pc_exec = pc_plus4;
         4'h4: if (vx != nn) pc_exec = pc_plus4;
         4'h5, 4'h9: begin
            if (n == 4'h0 && ((vx == vy) ^ opc[15])) pc_exec = pc_plus4;
         end
         4'hB: pc_exec = nnn + {4'b0, v_ff[0]};
         4'hE: begin
            if ((nn == NN_SKP && keys_ff[vx[3:0]]) || (nn == NN_SKNP && !keys_ff[vx[3:0]]))
               pc_exec = pc_plus4;
         end
         default: pc_exec = pc_plus2;
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_waddr = ix_addr;
      mem_wdata = v_ff[cmd.cnt[3:0]];
      mem_raddr = ix_addr;
      unique case (cmd.uop)
         UOP_LOAD: begin
            mem_we = 1'b1;
            mem_waddr = req_address;
            mem_wdata = req_data;
         end
         UOP_BCD: begin
            mem_we = 1'b1;
            mem_wdata = {4'b0, bcd_digit(vx, cmd.cnt[1:0])};
         end
         UOP_STORE: mem_we = 1'b1;
         UOP_FETCH_HI: mem_raddr = pc_ff;
         UOP_FETCH_LO: mem_raddr = pc_ff + 12'd1;
         default: mem_we = 1'b0;
      endcase
   end

   always_comb begin
      alu_r = vy;
      alu_f = 1'b0;
      alu_wf = 1'b1;
      alu_ok = 1'b1;
      alu_sum = {1'b0, vx} + {1'b0, vy};
      unique case (n)
         4'h0: alu_wf = 1'b0;
         4'h1: begin alu_r = vx | vy; alu_wf = 1'b0; end
         4'h2: begin alu_r = vx & vy; alu_wf = 1'b0; end
         4'h3: begin alu_r = vx ^ vy; alu_wf = 1'b0; end
         4'h4: begin alu_r = alu_sum[7:0]; alu_f = alu_sum[8]; end
         4'h5: begin alu_r = vx - vy; alu_f = (vx >= vy); end
         4'h6: begin alu_r = {1'b0, vx[7:1]}; alu_f = vx[0]; end
         4'h7: begin alu_r = vy - vx; alu_f = (vy >= vx); end
         4'hE: begin alu_r = {vx[6:0], 1'b0}; alu_f = vx[7]; end
         default: begin alu_ok = 1'b0; alu_wf = 1'b0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack[depth_ff[SW-1:0]] <= pc_plus2;
      end
      if (cmd.uop == UOP_RET_RD) begin
         stk_q_ff <= stack[depth_m1[SW-1:0]];
      end
   end

   // item payload: opcode, latched keys and random byte, row read
   always_ff @(posedge clock) begin
      unique case (cmd.uop)
         UOP_START: begin
            keys_ff <= req_keys_down;
            rnd_ff <= req_random_byte;
            row_ff <= '0;
         end
         UOP_LOAD, UOP_RESUME: row_ff <= '0;
         UOP_ROW: row_ff <= frame_ff[req_address[4:0]];
         UOP_FETCH_LO: op_hi_ff <= mem_q_ff;
         UOP_LATCH: op_lo_ff <= mem_q_ff;
         default: row_ff <= row_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) v_ff[k] <= '0;
         for (int k = 0; k < SCREEN_HEIGHT; k++) frame_ff[k] <= '0;
         pc_ff <= PC_RESET;
         i_ff <= '0;
         depth_ff <= '0;
         delay_ff <= '0;
         sound_ff <= '0;
         wait_ff <= 1'b0;
         target_ff <= '0;
         draw_ff <= 1'b0;
         hit_ff <= 1'b0;
         fault_ff <= FAULT_NONE;
      end else begin
         unique case (cmd.uop)
            UOP_LOAD, UOP_ROW, UOP_START: begin
               draw_ff <= 1'b0;
               fault_ff <= FAULT_NONE;
            end
            UOP_RESUME: begin
               draw_ff <= 1'b0;
               fault_ff <= FAULT_NONE;
               if (wait_ff) begin
                  v_ff[target_ff] <= req_data;
                  wait_ff <= 1'b0;
               end
            end
            UOP_EXEC: begin
               pc_ff <= pc_exec;
               hit_ff <= 1'b0;
               unique case (opc[15:12])
                  GRP_SYS: begin
                     if (opc == OPC_CLS) begin
                        for (int k = 0; k < SCREEN_HEIGHT; k++) frame_ff[k] <= '0;
                        draw_ff <= 1'b1;
                     end else if (opc == OPC_RET && depth_ff == '0) begin
                        fault_ff <= FAULT_UNDERFLOW;
                     end
                  end
                  4'h1, 4'h3, 4'h4, 4'hB: hit_ff <= 1'b0;
                  4'h2: begin
                     if (stack_full) begin
                        fault_ff <= FAULT_OVERFLOW;
                     end else begin
                        depth_ff <= depth_ff + 1'b1;
                     end
                  end
                  4'h5, 4'h9: begin
                     if (n != 4'h0) fault_ff <= FAULT_UNDEF;
                  end
                  4'h6: v_ff[x] <= nn;
                  4'h7: v_ff[x] <= vx + nn;
                  4'h8: begin
                     // drop the result when x is the flag register and the op writes the flag: the flag wins
                     if (alu_ok && !(alu_wf && x == 4'hF)) begin
                        v_ff[x] <= alu_r;
                     end else if (!alu_ok) begin
                        fault_ff <= FAULT_UNDEF;
                     end
                     if (alu_wf) v_ff[15] <= {7'b0, alu_f};
                  end
                  4'hA: i_ff <= {4'b0, nnn};
                  4'hC: v_ff[x] <= rnd_ff & nn;
                  GRP_DRAW: draw_ff <= 1'b1;
                  4'hE: begin
                     if (nn != NN_SKP && nn != NN_SKNP) fault_ff <= FAULT_UNDEF;
                  end
                  default: begin
                     case (nn)
                        NN_GET_DT: v_ff[x] <= delay_ff;
                        NN_WAIT: begin
                           wait_ff <= 1'b1;
                           target_ff <= x;
                        end
                        NN_SET_DT: delay_ff <= vx;
                        NN_SET_ST: sound_ff <= vx;
                        NN_ADD_I: begin
                           i_ff <= isum;
                           v_ff[15] <= {7'b0, (isum[15:12] != 4'b0)};
                        end
                        NN_FONT: i_ff <= {8'b0, vx} * 16'd5;
                        NN_BCD, NN_STORE, NN_LOAD: fault_ff <= FAULT_NONE;
                        default: fault_ff <= FAULT_UNDEF;
                     endcase
                  end
               endcase
            end
            UOP_RET_RD: depth_ff <= depth_m1;
            UOP_RET_DO: pc_ff <= stk_q_ff;
            UOP_LOADV: begin
               if (cmd.cnt != 5'd0) v_ff[4'(cmd.cnt - 5'd1)] <= mem_q_ff;
            end
            UOP_DRAW: begin
               if (draw_ok) frame_ff[draw_y[4:0]] <= frame_ff[draw_y[4:0]] ^ draw_bits;
               if (cmd.cnt == {1'b0, n}) begin
                  v_ff[15] <= {7'b0, hit_ff | draw_hit};
               end else begin
                  hit_ff <= hit_ff | draw_hit;
               end
            end
            default: hit_ff <= hit_ff;
         endcase
      end
   end

   assign rsp_program_counter = pc_ff;
   assign rsp_draw_flag = draw_ff;
   assign rsp_waiting_for_key = wait_ff;
   assign rsp_fault_code = fault_ff;
   assign rsp_screen_row = row_ff;
   assign rsp_delay_value = delay_ff;
   assign rsp_sound_value = sound_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH)) else $error("stack depth beyond capacity");
   a_ret_pops: assert property (@(posedge clock) disable iff (reset)
      cmd.uop == UOP_RET_RD |=> depth_ff == $past(depth_ff) - 1'b1)
      else $error("return did not pop");
   a_fault_no_draw: assert property (@(posedge clock) disable iff (reset)
      fault_ff != FAULT_NONE |-> !draw_ff) else $error("fault with draw");

endmodule

`default_nettype wire

// ===== rtl/c8_ctrl.sv =====
`default_nettype none

module c8_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_operation,
   output logic rsp_valid,
   input wire logic rsp_ready,
   input c8_pkg::status_type status,
   output c8_pkg::cmd_type cmd
);
   import c8_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_FETCH_HI = 12'b000000000010,
      S_FETCH_LO = 12'b000000000100,
      S_LATCH    = 12'b000000001000,
      S_EXEC     = 12'b000000010000,
      S_RET_RD   = 12'b000000100000,
      S_RET_DO   = 12'b000001000000,
      S_BCD      = 12'b000010000000,
      S_STORE    = 12'b000100000000,
      S_LOADV    = 12'b001000000000,
      S_DRAW     = 12'b010000000000,
      S_RESP     = 12'b100000000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [3:0] x, n;
   logic accept;

   assign x = status.opcode[11:8];
   assign n = status.opcode[3:0];
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = (state_ff == S_RESP);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff + 5'd1;
      cmd.uop = UOP_IDLE;
      cmd.cnt = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = S_RESP;
               unique case (req_operation)
                  OPER_LOAD: cmd.uop = UOP_LOAD;
                  OPER_RESUME: cmd.uop = UOP_RESUME;
                  OPER_ROW: cmd.uop = UOP_ROW;
                  default: begin
                     cmd.uop = UOP_START;
                     if (!status.waiting) state_in = S_FETCH_HI;
                  end
               endcase
            end
         end
         S_FETCH_HI: begin cmd.uop = UOP_FETCH_HI; state_in = S_FETCH_LO; end
         S_FETCH_LO: begin cmd.uop = UOP_FETCH_LO; state_in = S_LATCH; end
         S_LATCH: begin cmd.uop = UOP_LATCH; state_in = S_EXEC; end
         S_EXEC: begin
            cmd.uop = UOP_EXEC;
            cnt_in = '0;
            state_in = S_RESP;
            if (status.opcode == OPC_RET && !status.stack_empty) begin
               state_in = S_RET_RD;
            end else if (status.opcode[15:12] == GRP_DRAW) begin
               state_in = S_DRAW;
            end else if (status.opcode[15:12] == GRP_MISC) begin
               case (status.opcode[7:0])
                  NN_BCD: state_in = S_BCD;
                  NN_STORE: state_in = S_STORE;
                  NN_LOAD: state_in = S_LOADV;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_RET_RD: begin cmd.uop = UOP_RET_RD; state_in = S_RET_DO; end
         S_RET_DO: begin cmd.uop = UOP_RET_DO; state_in = S_RESP; end
         S_BCD: begin
            cmd.uop = UOP_BCD;
            if (cnt_ff == 5'd2) state_in = S_RESP;
         end
         S_STORE: begin
            cmd.uop = UOP_STORE;
            if (cnt_ff == {1'b0, x}) state_in = S_RESP;
         end
         S_LOADV: begin
            // one read ahead of the register write
            cmd.uop = UOP_LOADV;
            if (cnt_ff == ({1'b0, x} + 5'd1)) state_in = S_RESP;
         end
         S_DRAW: begin
            cmd.uop = UOP_DRAW;
            if (cnt_ff == {1'b0, n}) state_in = S_RESP;
         end
         S_RESP: begin
            cnt_in = '0;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE) else $error("transfer accepted but idle");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request and response open together");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 5'd17) else $error("step counter out of range");

endmodule

`default_nettype wire

// ===== rtl/chip8_instruction_core.sv =====
// CHIP-8 instruction core.
// req_chan carries one operation per transfer: load a program byte, execute
// one instruction, resume a key wait with the key in data, or read a screen
// row (address bits 4..0). rsp_chan returns exactly one result per request:
// PC, draw flag, key-wait flag, fault code, the requested row (zero for other
// operations) and both timer values.
// One request is in flight at a time; the next is taken once the result has
// been transferred. Load, resume and row read go straight to the result.
// Execute steps through fetch high, fetch low, latch and execute; a return
// then adds a stack read and a PC load, and BCD store, register block store,
// block load and sprite draw add a run of steps on the one memory port.
// Execute while a key wait is pending goes straight to the result, no change.
// Synchronous reset clears the registers, stack depth, screen and timers and
// sets PC to 0x200; program memory holds whatever was written.
// A stalled result holds on rsp_chan until rsp_chan.ready.
`default_nettype none

module chip8_instruction_core #(
   parameter int STACK_DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   c8_req_if.sink req_chan,
   c8_rsp_if.source rsp_chan
);
   import c8_pkg::*;

   cmd_type cmd;
   status_type status;

   c8_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .req_operation(req_chan.operation),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .status(status),
      .cmd(cmd)
   );

   c8_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_address(req_chan.address),
      .req_data(req_chan.data),
      .req_keys_down(req_chan.keys_down),
      .req_random_byte(req_chan.random_byte),
      .rsp_program_counter(rsp_chan.program_counter),
      .rsp_draw_flag(rsp_chan.draw_flag),
      .rsp_waiting_for_key(rsp_chan.waiting_for_key),
      .rsp_fault_code(rsp_chan.fault_code),
      .rsp_screen_row(rsp_chan.screen_row),
      .rsp_delay_value(rsp_chan.delay_value),
      .rsp_sound_value(rsp_chan.sound_value)
   );

endmodule

`default_nettype wire

// ===== sim/chip8_instruction_core_tb.sv =====
`timescale 1ns / 1ps

module chip8_instruction_core_tb;
   import c8_pkg::*;

   localparam int CORE_STACK = 16;
   localparam int RANDOM_ITEMS = 950;
   localparam int IDLE_LIMIT = 4000;
   localparam int DIR_ROWS = 24;

   typedef struct packed {
      logic [1:0] op;
      logic [11:0] addr;
      logic [7:0] data;
      logic [15:0] keys;
      logic [7:0] rnd;
   } core_req_type;

   typedef struct packed {
      logic [11:0] pc;
      logic draw;
      logic waiting;
      logic [1:0] fault;
      logic [63:0] row;
      logic [7:0] dt;
      logic [7:0] st;
   } core_rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic [11:0] addr;
      logic [7:0] data;
      logic [15:0] keys;
      logic [7:0] rnd;
      logic typed;
      logic [11:0] pc;
      logic [1:0] fault;
   } dir_row_type;

   logic clock;
   logic reset;
   c8_req_if req_chan ();
   c8_rsp_if rsp_chan ();

   chip8_instruction_core #(.STACK_DEPTH(CORE_STACK)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // shadow copy of the core
   logic [7:0] mem [4096];
   bit mem_ok [4096];
   logic [7:0] v [16];
   logic [11:0] pc_q;
   logic [15:0] idx_q;
   logic [11:0] stack_q [CORE_STACK];
   int depth_q;
   logic [63:0] frame_q [32];
   logic [7:0] dt_q, st_q;
   logic wait_q;
   logic [3:0] wait_reg;

   core_req_type send_items [$];
   core_rsp_type predicted_rsp [$];
   core_rsp_type pending_results [$];
   int accepted_reqs = 0;
   int drain_at;
   int fail_count = 0;
   int idle_cycles = 0;
   dir_row_type dir_rows [DIR_ROWS];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic put_byte(input logic [11:0] a, input logic [7:0] val);
      mem[a] = val;
      mem_ok[a] = 1'b1;
   endtask

   task automatic core_model_step(input core_req_type r, output core_rsp_type o);
      logic [15:0] opc;
      logic [3:0] x, y, nib;
      logic [7:0] nn, a, b;
      logic [11:0] nnn;
      logic [8:0] sum;
      logic [16:0] s;
      logic [63:0] bits;
      logic skip, hit;
      int yy;
      o = '0;
      case (r.op)
         OPER_LOAD: put_byte(r.addr, r.data);
         OPER_RESUME: if (wait_q) begin
            v[wait_reg] = r.data;
            wait_q = 1'b0;
         end
         OPER_ROW: o.row = frame_q[r.addr[4:0]];
         default: if (!wait_q) begin
            opc = {mem[pc_q], mem[pc_q + 12'd1]};
            x = opc[11:8];
            y = opc[7:4];
            nib = opc[3:0];
            nn = opc[7:0];
            nnn = opc[11:0];
            skip = 1'b0;
            pc_q = pc_q + 12'd2;
            case (opc[15:12])
               GRP_SYS: if (opc == OPC_CLS) begin
                  for (int i = 0; i < 32; i++) frame_q[i] = '0;
                  o.draw = 1'b1;
               end else if (opc == OPC_RET) begin
                  if (depth_q == 0) o.fault = FAULT_UNDERFLOW;
                  else begin
                     depth_q--;
                     pc_q = stack_q[depth_q];
                  end
               end
               4'h1: pc_q = nnn;
               4'h2: if (depth_q >= CORE_STACK) o.fault = FAULT_OVERFLOW;
               else begin
                  stack_q[depth_q] = pc_q;
                  depth_q++;
                  pc_q = nnn;
               end
               4'h3: skip = (v[x] == nn);
               4'h4: skip = (v[x] != nn);
               4'h5: if (nib != 0) o.fault = FAULT_UNDEF; else skip = (v[x] == v[y]);
               4'h6: v[x] = nn;
               4'h7: v[x] = v[x] + nn;
               4'h8: begin
                  a = v[x];
                  b = v[y];
                  case (nib)
                     4'h0: v[x] = b;
                     4'h1: v[x] = a | b;
                     4'h2: v[x] = a & b;
                     4'h3: v[x] = a ^ b;
                     4'h4: begin
                        sum = a + b;
                        v[x] = sum[7:0];
                        v[15] = {7'd0, sum[8]};
                     end
                     4'h5: begin
                        v[x] = a - b;
                        v[15] = {7'd0, a >= b};
                     end
                     4'h6: begin
                        v[x] = a >> 1;
                        v[15] = {7'd0, a[0]};
                     end
                     4'h7: begin
                        v[x] = b - a;
                        v[15] = {7'd0, b >= a};
                     end
                     4'hE: begin
                        v[x] = a << 1;
                        v[15] = {7'd0, a[7]};
                     end
                     default: o.fault = FAULT_UNDEF;
                  endcase
               end
               4'h9: if (nib != 0) o.fault = FAULT_UNDEF; else skip = (v[x] != v[y]);
               4'hA: idx_q = {4'h0, nnn};
               4'hB: pc_q = nnn + {4'h0, v[0]};
               4'hC: v[x] = r.rnd & nn;
               GRP_DRAW: begin
                  hit = 1'b0;
                  for (int i = 0; i < nib; i++) begin
                     yy = v[y] + i;
                     if (yy < SCREEN_HEIGHT && v[x] < SCREEN_WIDTH) begin
                        bits = {mem[idx_q[11:0] + 12'(i)], 56'd0} >> v[x];
                        if ((frame_q[yy] & bits) != 0) hit = 1'b1;
                        frame_q[yy] = frame_q[yy] ^ bits;
                     end
                  end
                  v[15] = {7'd0, hit};
                  o.draw = 1'b1;
               end
               4'hE: if (nn == NN_SKP) skip = r.keys[v[x][3:0]];
               else if (nn == NN_SKNP) skip = !r.keys[v[x][3:0]];
               else o.fault = FAULT_UNDEF;
               default: case (nn)
                  NN_GET_DT: v[x] = dt_q;
                  NN_WAIT: begin
                     wait_q = 1'b1;
                     wait_reg = x;
                  end
                  NN_SET_DT: dt_q = v[x];
                  NN_SET_ST: st_q = v[x];
                  NN_ADD_I: begin
                     s = idx_q + v[x];
                     idx_q = s[15:0];
                     v[15] = {7'd0, s[15:0] > 16'h0FFF};
                  end
                  NN_FONT: idx_q = v[x] * 16'd5;
                  NN_BCD: begin
                     put_byte(idx_q[11:0], 8'(v[x] / 100));
                     put_byte(idx_q[11:0] + 12'd1, 8'((v[x] / 10) % 10));
                     put_byte(idx_q[11:0] + 12'd2, 8'(v[x] % 10));
                  end
                  NN_STORE: for (int i = 0; i <= x; i++) put_byte(idx_q[11:0] + 12'(i), v[i]);
                  NN_LOAD: for (int i = 0; i <= x; i++) v[i] = mem[idx_q[11:0] + 12'(i)];
                  default: o.fault = FAULT_UNDEF;
               endcase
            endcase
            if (skip) pc_q = pc_q + 12'd2;
         end
      endcase
      o.pc = pc_q;
      o.waiting = wait_q;
      o.dt = dt_q;
      o.st = st_q;
   endtask

   task automatic queue_item(input core_req_type r);
      core_rsp_type o;
      core_model_step(r, o);
      send_items.insert(send_items.size(), r);
      predicted_rsp.insert(predicted_rsp.size(), o);
   endtask

   task automatic queue_simple(input logic [1:0] op, input logic [11:0] a, input logic [7:0] d);
      core_req_type r;
      r.op = op;
      r.addr = a;
      r.data = d;
      r.keys = 16'($urandom);
      r.rnd = 8'($urandom);
      queue_item(r);
   endtask

   task automatic fill_byte(input logic [11:0] a);
      if (!mem_ok[a]) queue_simple(OPER_LOAD, a, 8'($urandom));
   endtask

   function automatic logic [15:0] pick_opcode(input bit force_call);
      logic [15:0] opc;
      logic [3:0] grp;
      opc = 16'($urandom);
      grp = force_call ? 4'h2 : 4'($urandom);
      opc[15:12] = grp;
      case (grp)
         GRP_SYS: case ($urandom_range(0, 3))
            0: opc = OPC_CLS;
            1, 2: opc = OPC_RET;
            default: ;
         endcase
         4'h5, 4'h9: if ($urandom_range(0, 4) != 0) opc[3:0] = 4'h0;
         4'h6: if ($urandom_range(0, 1) != 0) opc[7:0] = 8'($urandom_range(0, 63));
         4'h8: if ($urandom_range(0, 7) != 0) begin
            opc[3:0] = 4'($urandom_range(0, 8));
            if (opc[3:0] == 4'h8) opc[3:0] = 4'hE;
         end
         4'hE: case ($urandom_range(0, 4))
            0: ;
            1, 2: opc[7:0] = NN_SKP;
            default: opc[7:0] = NN_SKNP;
         endcase
         GRP_MISC: case ($urandom_range(0, 11))
            0: opc[7:0] = NN_GET_DT;
            1: opc[7:0] = NN_WAIT;
            2: opc[7:0] = NN_SET_DT;
            3: opc[7:0] = NN_SET_ST;
            4: opc[7:0] = NN_ADD_I;
            5: opc[7:0] = NN_FONT;
            6: opc[7:0] = NN_BCD;
            7, 8: opc[7:0] = NN_STORE;
            9, 10: opc[7:0] = NN_LOAD;
            default: ;
         endcase
         default: ;
      endcase
      return opc;
   endfunction

   // plant an instruction at PC on a forced call, at random or when PC is unset, and every byte it will read
   task automatic queue_exec(input bit force_call);
      logic [15:0] opc;
      if (!wait_q) begin
         if (force_call || $urandom_range(0, 9) < 7 || !mem_ok[pc_q] || !mem_ok[pc_q + 12'd1])
         begin
            opc = pick_opcode(force_call);
            queue_simple(OPER_LOAD, pc_q, opc[15:8]);
            queue_simple(OPER_LOAD, pc_q + 12'd1, opc[7:0]);
         end
         opc = {mem[pc_q], mem[pc_q + 12'd1]};
         if (opc[15:12] == GRP_DRAW)
            for (int i = 0; i < opc[3:0]; i++) fill_byte(idx_q[11:0] + 12'(i));
         if (opc[15:12] == GRP_MISC && opc[7:0] == NN_LOAD)
            for (int i = 0; i <= opc[11:8]; i++) fill_byte(idx_q[11:0] + 12'(i));
      end
      queue_simple(OPER_EXEC, 12'($urandom), 8'($urandom));
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // compare results, log accepted requests, watch for a hang
   always @(posedge clock) begin
      core_rsp_type e;
      if (!reset) begin
         idle_cycles++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            idle_cycles = 0;
            if (pending_results.size() == 0) begin
               $display("%0t: result transfer with nothing expected, pc %h", $time,
                        rsp_chan.program_counter);
               fail_count++;
            end else begin
               e = pending_results.pop_front();
               check_field("program_counter", 64'(e.pc), 64'(rsp_chan.program_counter));
               check_field("draw_flag", 64'(e.draw), 64'(rsp_chan.draw_flag));
               check_field("waiting_for_key", 64'(e.waiting), 64'(rsp_chan.waiting_for_key));
               check_field("fault_code", 64'(e.fault), 64'(rsp_chan.fault_code));
               check_field("screen_row", e.row, rsp_chan.screen_row);
               check_field("delay_value", 64'(e.dt), 64'(rsp_chan.delay_value));
               check_field("sound_value", 64'(e.st), 64'(rsp_chan.sound_value));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            idle_cycles = 0;
            pending_results.insert(pending_results.size(), predicted_rsp[accepted_reqs]);
            accepted_reqs++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver: free-flowing stretches, then random stalls
   always @(negedge clock) begin
      int phase;
      phase = int'(($time / 12) % 96);
      if (reset) rsp_chan.ready <= 1'b0;
      else if (phase < 24) rsp_chan.ready <= 1'b1;
      else if (phase < 60) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      else rsp_chan.ready <= ($urandom_range(0, 2) == 0);
   end

   initial begin
      core_req_type r;
      core_rsp_type o;
      int burst;
      int gap;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.operation = OPER_LOAD;
      req_chan.address = '0;
      req_chan.data = '0;
      req_chan.keys_down = '0;
      req_chan.random_byte = '0;

      for (int i = 0; i < 4096; i++) begin
         mem[i] = '0;
         mem_ok[i] = 1'b0;
      end
      for (int i = 0; i < 16; i++) v[i] = '0;
      for (int i = 0; i < 32; i++) frame_q[i] = '0;
      for (int i = 0; i < CORE_STACK; i++) stack_q[i] = '0;
      pc_q = PC_RESET;
      idx_q = '0;
      depth_q = 0;
      dt_q = '0;
      st_q = '0;
      wait_q = 1'b0;
      wait_reg = '0;

      dir_rows = '{
         '{OPER_ROW, 12'h01F, 8'h00, 16'h0000, 8'h00, 1'b1, 12'h200, FAULT_NONE},
         '{OPER_LOAD, 12'h200, 8'h00, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_LOAD, 12'h201, 8'hEE, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b1, 12'h202, FAULT_UNDERFLOW},
         '{OPER_LOAD, 12'h202, 8'h5A, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_LOAD, 12'h203, 8'h31, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b1, 12'h204, FAULT_UNDEF},
         '{OPER_LOAD, 12'h204, 8'h60, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_LOAD, 12'h205, 8'hFF, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_EXEC, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 12'h206, FAULT_NONE},
         '{OPER_LOAD, 12'h206, 8'hF3, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_LOAD, 12'h207, 8'h0A, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b1, 12'h208, FAULT_NONE},
         '{OPER_EXEC, 12'h000, 8'h00, 16'hFFFF, 8'hFF, 1'b1, 12'h208, FAULT_NONE},
         '{OPER_RESUME, 12'h000, 8'hFF, 16'h0000, 8'h00, 1'b1, 12'h208, FAULT_NONE},
         '{OPER_RESUME, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b1, 12'h208, FAULT_NONE},
         '{OPER_LOAD, 12'h208, 8'hA2, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_LOAD, 12'h209, 8'h00, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b1, 12'h20A, FAULT_NONE},
         '{OPER_LOAD, 12'h20A, 8'hD1, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_LOAD, 12'h20B, 8'h15, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00, 1'b1, 12'h20C, FAULT_NONE},
         '{OPER_ROW, 12'hFE0, 8'h00, 16'h0000, 8'h00, 1'b0, 12'h000, FAULT_NONE},
         '{OPER_LOAD, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 12'h000, FAULT_NONE}
      };
      foreach (dir_rows[i]) begin
         r = '{dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].keys,
               dir_rows[i].rnd};
         core_model_step(r, o);
         if (dir_rows[i].typed) begin
            o.pc = dir_rows[i].pc;
            o.fault = dir_rows[i].fault;
         end
         send_items.insert(send_items.size(), r);
         predicted_rsp.insert(predicted_rsp.size(), o);
      end

      drain_at = -1;
      while (send_items.size() < RANDOM_ITEMS + DIR_ROWS) begin
         if (drain_at < 0 && send_items.size() > 450) begin
            // drain, then nest calls past the stack limit
            drain_at = send_items.size();
            if (wait_q) queue_simple(OPER_RESUME, '0, 8'($urandom));
            for (int i = 0; i < CORE_STACK + 2; i++) queue_exec(1'b1);
         end
         case ($urandom_range(0, 19))
            0, 1: queue_simple(OPER_RESUME, 12'($urandom), 8'($urandom));
            2, 3: queue_simple(OPER_ROW, 12'($urandom), 8'($urandom));
            4, 5: queue_simple(OPER_LOAD, 12'($urandom), 8'($urandom));
            default: queue_exec(1'b0);
         endcase
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      burst = 0;
      foreach (send_items[k]) begin
         if (k == drain_at)
            while (pending_results.size() != 0) @(negedge clock);
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge clock);
         end
         burst--;
         req_chan.operation = send_items[k].op;
         req_chan.address = send_items[k].addr;
         req_chan.data = send_items[k].data;
         req_chan.keys_down = send_items[k].keys;
         req_chan.random_byte = send_items[k].rnd;
         req_chan.valid = 1'b1;
         do @(posedge clock); while (!req_chan.ready);
         @(negedge clock);
         req_chan.valid = 1'b0;
      end

      while (pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
